@@ rtl/s2s_pkg.sv @@
// Shared types and constants for the servo-to-stepper position map.
// Used by s2s_cfg, s2s_muldiv and servo_to_stepper_map; depends on nothing.
package s2s_pkg;

    // Defaults for the top-level parameters.
    localparam int STEP_BITS_DEF  = 20;
    localparam int SERVO_BITS_DEF = 16;

    // Fixed field widths of the item and register formats.
    localparam int FUNC_W     = 2;
    localparam int SERVO_W    = 16;
    localparam int SV_W       = 21;
    localparam int STEPF_W    = 20;
    localparam int COUNT_W    = 20;
    localparam int DSTEP_W    = STEPF_W + 1;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 20;
    localparam int S_TDATA_W  = 40;
    localparam int M_TDATA_W  = 64;

    // Bit positions of the result fields in m_axis_tdata.
    localparam int MV_VALID_BIT = 0;
    localparam int MV_REV_BIT   = 1;
    localparam int MV_CNT_LSB   = 2;
    localparam int TGT_LSB      = MV_CNT_LSB + COUNT_W;
    localparam int POS_LSB      = TGT_LSB + STEPF_W;
    localparam int RES_W        = POS_LSB + STEPF_W;

    localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

    typedef enum logic [FUNC_W-1:0] {
        FN_GOTO = 2'd0,
        FN_HOME = 2'd1,
        FN_MOVE = 2'd2,
        FN_SET  = 2'd3
    } func_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_CAL         = 3'd0,
        REG_SERVO_LOW   = 3'd1,
        REG_SERVO_HIGH  = 3'd2,
        REG_STEPS_LEFT  = 3'd3,
        REG_STEPS_MID   = 3'd4,
        REG_STEPS_RIGHT = 3'd5
    } cfg_idx_t;

    typedef struct packed {
        logic               calibrated;
        logic [SERVO_W-1:0] servo_low;
        logic [SERVO_W-1:0] servo_high;
        logic [STEPF_W-1:0] steps_left;
        logic [STEPF_W-1:0] steps_middle;
        logic [STEPF_W-1:0] steps_right;
    } cfg_t;

    typedef struct packed {
        logic busy;
        logic done;
    } md_stat_t;

endpackage

@@ rtl/servo_to_stepper_map.sv @@
// Top level of the servo-to-stepper position map: command sequencer, position
// tracking, saturation and the result register.
// Depends on s2s_pkg, s2s_cfg and s2s_muldiv.
//
//  channel   | direction | handshake                   | payload
//  ----------+-----------+-----------------------------+---------------------------------
//  s_axis    | in        | s_axis_tvalid/s_axis_tready | tuser: func; tdata: servo, steps
//  m_axis    | out       | m_axis_tvalid/m_axis_tready | tdata: move and position result
//  cfg       | in        | cfg_wr_en, no wait          | cfg_index, cfg_data
//
// A calibrated goto runs the midpoint and segment set-up, the bit-serial multiply and
// divide, the saturating sum and the delta before the result is loaded; a zero-span
// goto skips the multiply-divide, move-by and set-position run the saturator and the
// delta, an uncalibrated goto only the delta. The next item can be taken in the cycle
// after the load; a full result register holds an item in ST_DONE until m_axis_tready.
// Reset is synchronous, active low, and clears the calibration and the position.
module servo_to_stepper_map
    import s2s_pkg::*;
#(
    parameter int STEP_BITS  = STEP_BITS_DEF,
    parameter int SERVO_BITS = SERVO_BITS_DEF
)
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    input  logic [S_TDATA_W-1:0]  s_axis_tdata,  // servo_target[15:0], step_value[36:16]
    input  logic [FUNC_W-1:0]     s_axis_tuser,  // func[1:0]
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    output logic [M_TDATA_W-1:0]  m_axis_tdata,  // move_valid[0], move_reverse[1],
                                                 // move_count[21:2], target_steps[41:22],
                                                 // position_now[61:42]
    input  logic                  cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    localparam int SP_W  = SERVO_BITS + 1;
    localparam int QW    = DSTEP_W + SERVO_BITS;
    localparam int ADD_W = (STEP_BITS > SV_W ? STEP_BITS : SV_W) + 1;
    localparam int SUM_W = QW + 1;
    localparam int SAT_W = SUM_W > ADD_W ? SUM_W : ADD_W;
    localparam int EXT_W = STEP_BITS > STEPF_W ? STEP_BITS : STEPF_W;
    localparam int DLT_W = STEP_BITS + 1;
    localparam int MAG_W = DLT_W > COUNT_W ? DLT_W : COUNT_W;

    localparam logic signed [SAT_W-1:0] STEP_MAX =
        SAT_W'((longint'(1) <<< (STEP_BITS - 1)) - longint'(1));
    localparam logic signed [SAT_W-1:0] STEP_MIN = -STEP_MAX - SAT_W'(1);

    typedef enum logic [8:0] {
        ST_IDLE  = 9'b000000001,
        ST_MID   = 9'b000000010,
        ST_SEG   = 9'b000000100,
        ST_DIV   = 9'b000001000,
        ST_SUM   = 9'b000010000,
        ST_ADD   = 9'b000100000,
        ST_SET   = 9'b001000000,
        ST_DELTA = 9'b010000000,
        ST_DONE  = 9'b100000000
    } st_t;

    cfg_t     cfg;
    md_stat_t md_stat;
    logic signed [QW-1:0] md_q;

    st_t                         state_reg, state_next;
    logic [SERVO_BITS-1:0]       servo_reg, servo_next;
    logic signed [SV_W-1:0]      sv_reg, sv_next;
    logic signed [STEP_BITS-1:0] pos_reg, pos_next;
    logic [SERVO_BITS-1:0]       mid_reg, mid_next;
    logic signed [STEPF_W-1:0]   base_reg, base_next;
    logic                        zero_reg, zero_next;
    logic signed [STEP_BITS-1:0] tgt_reg, tgt_next;
    logic signed [DLT_W-1:0]     delta_reg, delta_next;
    logic                        m_valid_reg, m_valid_next;
    logic [M_TDATA_W-1:0]        m_data_reg, m_data_next;

    logic                        s_acc;
    logic                        out_load;
    logic [SERVO_BITS-1:0]       cal_low, cal_high;
    logic signed [STEPF_W-1:0]   st_left, st_mid, st_right;
    logic [SERVO_BITS:0]         mid_sum;
    logic                        seg_left;
    logic signed [DSTEP_W-1:0]   seg_a;
    logic signed [SP_W-1:0]      seg_b, seg_d;
    logic                        md_start;
    logic signed [SAT_W-1:0]     sat_in;
    logic signed [STEP_BITS-1:0] sat_out;
    logic [MAG_W-1:0]            mag;
    logic [COUNT_W-1:0]          count;
    logic signed [EXT_W-1:0]     tgt_ext;
    logic                        mv_valid;

    s2s_cfg u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    s2s_muldiv #(
        .SERVO_BITS (SERVO_BITS)
    ) u_muldiv (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (md_start),
        .a_in    (seg_a),
        .b_in    (seg_b),
        .d_in    (seg_d),
        .stat    (md_stat),
        .q       (md_q)
    );

    assign s_axis_tready = state_reg == ST_IDLE;
    assign s_acc         = s_axis_tvalid && s_axis_tready;
    assign out_load      = (state_reg == ST_DONE) && (!m_valid_reg || m_axis_tready);

    assign cal_low  = cfg.servo_low[SERVO_BITS-1:0];
    assign cal_high = cfg.servo_high[SERVO_BITS-1:0];
    assign st_left  = $signed(cfg.steps_left);
    assign st_mid   = $signed(cfg.steps_middle);
    assign st_right = $signed(cfg.steps_right);

    assign mid_sum = {1'b0, cal_low} + {1'b0, cal_high};

    // Segment set-up: the left segment covers positions up to the midpoint.
    assign seg_left = servo_reg <= mid_reg;
    assign seg_a = seg_left ? DSTEP_W'(st_mid) - DSTEP_W'(st_left)
                            : DSTEP_W'(st_right) - DSTEP_W'(st_mid);
    assign seg_b = $signed({1'b0, servo_reg}) - $signed({1'b0, seg_left ? cal_low : mid_reg});
    assign seg_d = seg_left ? $signed({1'b0, mid_reg}) - $signed({1'b0, cal_low})
                            : $signed({1'b0, cal_high}) - $signed({1'b0, mid_reg});
    assign md_start = (state_reg == ST_SEG) && (seg_d != '0);

    // One saturator serves the mapped target, move-by and set-position.
    always_comb begin
        case (state_reg)
            ST_SUM:  sat_in = SAT_W'(base_reg) + (zero_reg ? '0 : SAT_W'(md_q));
            ST_ADD:  sat_in = SAT_W'(pos_reg) + SAT_W'(sv_reg);
            default: sat_in = SAT_W'(sv_reg);
        endcase
        if (sat_in > STEP_MAX) begin
            sat_out = STEP_BITS'(STEP_MAX);
        end else if (sat_in < STEP_MIN) begin
            sat_out = STEP_BITS'(STEP_MIN);
        end else begin
            sat_out = STEP_BITS'(sat_in);
        end
    end

    assign mag      = delta_reg[DLT_W-1] ? MAG_W'(-delta_reg) : MAG_W'(delta_reg);
    assign count    = (mag > MAG_W'(COUNT_MAX)) ? COUNT_MAX : COUNT_W'(mag);
    assign mv_valid = delta_reg != '0;
    assign tgt_ext  = EXT_W'(tgt_reg);

    always_comb begin
        state_next   = state_reg;
        servo_next   = servo_reg;
        sv_next      = sv_reg;
        pos_next     = pos_reg;
        mid_next     = mid_reg;
        base_next    = base_reg;
        zero_next    = zero_reg;
        tgt_next     = tgt_reg;
        delta_next   = delta_reg;
        m_data_next  = m_data_reg;
        m_valid_next = m_valid_reg && !m_axis_tready;
        case (state_reg)
            ST_IDLE: begin
                if (s_acc) begin
                    servo_next = s_axis_tdata[SERVO_BITS-1:0];
                    sv_next    = $signed(s_axis_tdata[SERVO_W +: SV_W]);
                    case (s_axis_tuser)
                        FN_GOTO, FN_HOME: begin
                            if (s_axis_tuser == FN_HOME) begin
                                servo_next = cal_low;
                            end
                            if (cfg.calibrated) begin
                                state_next = ST_MID;
                            end else begin
                                // Nothing moves; the target reads as the position.
                                tgt_next   = pos_reg;
                                state_next = ST_DELTA;
                            end
                        end
                        FN_MOVE: state_next = ST_ADD;
                        FN_SET:  state_next = ST_SET;
                        default: state_next = ST_IDLE;
                    endcase
                end
            end
            ST_MID: begin
                mid_next   = mid_sum[SERVO_BITS:1];
                state_next = ST_SEG;
            end
            ST_SEG: begin
                base_next  = seg_left ? st_left : st_mid;
                zero_next  = seg_d == '0;
                state_next = (seg_d == '0) ? ST_SUM : ST_DIV;
            end
            ST_DIV: begin
                if (md_stat.done) begin
                    state_next = ST_SUM;
                end
            end
            ST_SUM, ST_ADD: begin
                tgt_next   = sat_out;
                state_next = ST_DELTA;
            end
            ST_SET: begin
                pos_next   = sat_out;
                tgt_next   = sat_out;
                state_next = ST_DELTA;
            end
            ST_DELTA: begin
                delta_next = DLT_W'(tgt_reg) - DLT_W'(pos_reg);
                state_next = ST_DONE;
            end
            ST_DONE: begin
                if (out_load) begin
                    // After any command the position equals its target.
                    pos_next     = tgt_reg;
                    m_valid_next = 1'b1;
                    m_data_next  = M_TDATA_W'({tgt_ext[STEPF_W-1:0], tgt_ext[STEPF_W-1:0],
                                               mv_valid ? count : '0,
                                               mv_valid && delta_reg[DLT_W-1], mv_valid});
                    state_next   = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            pos_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            pos_reg     <= pos_next;
            m_valid_reg <= m_valid_next;
        end
        servo_reg  <= servo_next;
        sv_reg     <= sv_next;
        mid_reg    <= mid_next;
        base_reg   <= base_next;
        zero_reg   <= zero_next;
        tgt_reg    <= tgt_next;
        delta_reg  <= delta_next;
        m_data_reg <= m_data_next;
    end

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = m_data_reg;

    a_md_busy_in_div: assert property (@(posedge aclk) disable iff (!aresetn)
        md_stat.busy |-> state_reg == ST_DIV)
        else $error("multiply-divide unit busy outside the divide wait");

    a_one_item: assert property (@(posedge aclk) disable iff (!aresetn)
        s_acc |=> !s_axis_tready)
        else $error("second item taken while one is in progress");

    a_pos_follows: assert property (@(posedge aclk) disable iff (!aresetn)
        out_load |=> pos_reg == $past(tgt_reg))
        else $error("position not updated to the target after a result");

    a_no_move_fields: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && !m_data_reg[MV_VALID_BIT]) |->
            (m_data_reg[TGT_LSB-1:MV_REV_BIT] == '0))
        else $error("direction or count set on a result without a move");

    a_move_nonzero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && m_data_reg[MV_VALID_BIT]) |->
            (m_data_reg[TGT_LSB-1:MV_CNT_LSB] != '0))
        else $error("move issued with a zero count");

endmodule

@@ rtl/s2s_cfg.sv @@
// Calibration register bank of the servo-to-stepper map.
// Depends on s2s_pkg for the register index codes and the cfg_t bundle.
module s2s_cfg
    import s2s_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    output cfg_t                  cfg
);

    cfg_t cfg_reg;
    cfg_t cfg_next;

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_wr_en) begin
            case (cfg_index)
                REG_CAL:         cfg_next.calibrated   = cfg_data[0];
                REG_SERVO_LOW:   cfg_next.servo_low    = cfg_data[SERVO_W-1:0];
                REG_SERVO_HIGH:  cfg_next.servo_high   = cfg_data[SERVO_W-1:0];
                REG_STEPS_LEFT:  cfg_next.steps_left   = cfg_data[STEPF_W-1:0];
                REG_STEPS_MID:   cfg_next.steps_middle = cfg_data[STEPF_W-1:0];
                REG_STEPS_RIGHT: cfg_next.steps_right  = cfg_data[STEPF_W-1:0];
                default:         cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg <= '0;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

@@ rtl/s2s_muldiv.sv @@
// Bit-serial signed multiply-then-divide unit: q = trunc(a * b / d), d nonzero.
// Shift-add multiply one bit a cycle, then restoring divide one bit a cycle.
// Depends on s2s_pkg for widths and the md_stat_t bundle.
module s2s_muldiv
    import s2s_pkg::*;
#(
    parameter int SERVO_BITS = SERVO_BITS_DEF
)
(
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               start,
    input  logic signed [DSTEP_W-1:0]          a_in,
    input  logic signed [SERVO_BITS:0]         b_in,
    input  logic signed [SERVO_BITS:0]         d_in,
    output md_stat_t                           stat,
    output logic signed [DSTEP_W+SERVO_BITS-1:0] q
);

    localparam int AM_W  = DSTEP_W - 1;
    localparam int PW    = AM_W + SERVO_BITS;
    localparam int QW    = PW + 1;
    localparam int CNT_W = $clog2(PW + 1);

    typedef enum logic [4:0] {
        MD_IDLE = 5'b00001,
        MD_ABS  = 5'b00010,
        MD_MUL  = 5'b00100,
        MD_DIV  = 5'b01000,
        MD_SIGN = 5'b10000
    } md_state_t;

    md_state_t                 state_reg, state_next;
    logic signed [DSTEP_W-1:0] a_reg, a_next;
    logic signed [SERVO_BITS:0] b_reg, b_next;
    logic signed [SERVO_BITS:0] d_reg, d_next;
    logic [AM_W-1:0]           am_reg, am_next;
    logic [SERVO_BITS-1:0]     dm_reg, dm_next;
    logic                      neg_reg, neg_next;
    logic [PW-1:0]             p_reg, p_next;
    logic [SERVO_BITS-1:0]     rem_reg, rem_next;
    logic [CNT_W-1:0]          cnt_reg, cnt_next;
    logic signed [QW-1:0]      q_reg, q_next;
    logic                      done_reg, done_next;

    logic signed [DSTEP_W-1:0] a_abs;
    logic signed [SERVO_BITS:0] b_abs;
    logic signed [SERVO_BITS:0] d_abs;
    logic [AM_W:0]             mul_sum;
    logic [SERVO_BITS:0]       trial;
    logic                      trial_ge;

    assign a_abs = a_reg[DSTEP_W-1] ? -a_reg : a_reg;
    assign b_abs = b_reg[SERVO_BITS] ? -b_reg : b_reg;
    assign d_abs = d_reg[SERVO_BITS] ? -d_reg : d_reg;

    // Upper half of the product register accumulates; the multiplier
    // bits shift out of the lower half.
    assign mul_sum = {1'b0, p_reg[PW-1:SERVO_BITS]}
                   + (p_reg[0] ? {1'b0, am_reg} : '0);

    assign trial    = {rem_reg, p_reg[PW-1]};
    assign trial_ge = trial >= {1'b0, dm_reg};

    always_comb begin
        state_next = state_reg;
        a_next     = a_reg;
        b_next     = b_reg;
        d_next     = d_reg;
        am_next    = am_reg;
        dm_next    = dm_reg;
        neg_next   = neg_reg;
        p_next     = p_reg;
        rem_next   = rem_reg;
        cnt_next   = cnt_reg;
        q_next     = q_reg;
        done_next  = 1'b0;
        case (state_reg)
            MD_IDLE: begin
                if (start) begin
                    a_next     = a_in;
                    b_next     = b_in;
                    d_next     = d_in;
                    state_next = MD_ABS;
                end
            end
            MD_ABS: begin
                am_next    = a_abs[AM_W-1:0];
                dm_next    = d_abs[SERVO_BITS-1:0];
                neg_next   = a_reg[DSTEP_W-1] ^ b_reg[SERVO_BITS] ^ d_reg[SERVO_BITS];
                p_next     = {{AM_W{1'b0}}, b_abs[SERVO_BITS-1:0]};
                cnt_next   = '0;
                state_next = MD_MUL;
            end
            MD_MUL: begin
                p_next   = {mul_sum, p_reg[SERVO_BITS-1:1]};
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == CNT_W'(SERVO_BITS - 1)) begin
                    cnt_next   = '0;
                    rem_next   = '0;
                    state_next = MD_DIV;
                end
            end
            MD_DIV: begin
                rem_next = trial_ge ? SERVO_BITS'(trial - {1'b0, dm_reg})
                                    : trial[SERVO_BITS-1:0];
                p_next   = {p_reg[PW-2:0], trial_ge};
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == CNT_W'(PW - 1)) begin
                    state_next = MD_SIGN;
                end
            end
            MD_SIGN: begin
                q_next     = neg_reg ? -$signed({1'b0, p_reg}) : $signed({1'b0, p_reg});
                done_next  = 1'b1;
                state_next = MD_IDLE;
            end
            default: state_next = MD_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= MD_IDLE;
            done_reg  <= 1'b0;
        end else begin
            state_reg <= state_next;
            done_reg  <= done_next;
        end
        a_reg   <= a_next;
        b_reg   <= b_next;
        d_reg   <= d_next;
        am_reg  <= am_next;
        dm_reg  <= dm_next;
        neg_reg <= neg_next;
        p_reg   <= p_next;
        rem_reg <= rem_next;
        cnt_reg <= cnt_next;
        q_reg   <= q_next;
    end

    assign stat.busy = state_reg != MD_IDLE;
    assign stat.done = done_reg;
    assign q         = q_reg;

endmodule

@@ tb/sv/tb_servo_to_stepper_map.sv @@
`timescale 1ns / 100ps
// Self-checking testbench for servo_to_stepper_map. It sends commands on s_axis,
// predicts each move report and compares m_axis against it. Depends on s2s_pkg.
module tb_servo_to_stepper_map
    import s2s_pkg::*;
();

    localparam int     CLK_HALF     = 4;
    localparam int     RAND_PHASES  = 13;
    localparam int     PHASE_ITEMS  = 150;
    localparam int     TAIL_CYCLES  = 70;
    localparam int     HOLD_CYCLES  = 300;
    localparam int     STEP_MAX_I   = 524287;
    localparam int     STEP_MIN_I   = -524288;
    localparam int     SV_MAX_I     = 1048575;
    localparam int     SERVO_MAX_I  = 65535;
    localparam longint STEP_HI      = 524287;
    localparam longint STEP_LO      = -524288;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_A = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_B = 3'd7;

    typedef struct packed {
        logic               mv_valid;
        logic               mv_rev;
        logic [COUNT_W-1:0] mv_count;
        logic [STEPF_W-1:0] target;
        logic [STEPF_W-1:0] position;
    } move_report_t;

    logic                  aclk = 1'b0;
    logic                  aresetn;
    logic                  s_axis_tvalid;
    logic                  s_axis_tready;
    logic [S_TDATA_W-1:0]  s_axis_tdata;   // servo_target[15:0], step_value[36:16]
    logic [FUNC_W-1:0]     s_axis_tuser;   // func[1:0]
    logic                  m_axis_tvalid;
    logic                  m_axis_tready;
    logic [M_TDATA_W-1:0]  m_axis_tdata;   // move_valid[0], move_reverse[1],
                                           // move_count[21:2], target_steps[41:22],
                                           // position_now[61:42]
    logic                  cfg_wr_en;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    // Calibration copy and tracked position of the predictor.
    logic   cal_done  = 1'b0;
    longint servo_lo  = 0;
    longint servo_hi  = 0;
    longint steps_l   = 0;
    longint steps_m   = 0;
    longint steps_r   = 0;
    longint track_pos = 0;

    move_report_t pending_moves[$];
    int           err_count = 0;
    logic         no_idle   = 1'b0;
    logic         hold_req  = 1'b0;
    logic         rx_hold   = 1'b0;

    servo_to_stepper_map uut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    always #CLK_HALF aclk = ~aclk;

    function automatic longint clamp_steps(longint v);
        if (v > STEP_HI) return STEP_HI;
        if (v < STEP_LO) return STEP_LO;
        return v;
    endfunction

    // Two-segment interpolation; the midpoint belongs to the left segment.
    function automatic longint interp_servo(longint p);
        longint mid;
        longint res;
        mid = (servo_lo + servo_hi) / 2;
        if (p <= mid) begin
            if (mid == servo_lo) res = steps_l;
            else res = steps_l + ((steps_m - steps_l) * (p - servo_lo)) / (mid - servo_lo);
        end else begin
            if (servo_hi == mid) res = steps_m;
            else res = steps_m + ((steps_r - steps_m) * (p - mid)) / (servo_hi - mid);
        end
        return clamp_steps(res);
    endfunction

    function automatic move_report_t predict_move(func_t fn, logic [SERVO_W-1:0] servo,
                                                  longint sv);
        move_report_t rep;
        longint       new_pos;
        longint       mag;
        logic         may_move;
        rep      = '0;
        may_move = 1'b1;
        case (fn)
            FN_GOTO, FN_HOME: begin
                if (!cal_done) begin
                    may_move = 1'b0;
                    new_pos  = track_pos;
                end else begin
                    new_pos = interp_servo(fn == FN_HOME ? servo_lo : longint'(servo));
                end
            end
            FN_MOVE: new_pos = clamp_steps(track_pos + sv);
            default: begin
                may_move  = 1'b0;
                track_pos = clamp_steps(sv);
                new_pos   = track_pos;
            end
        endcase
        if (may_move && new_pos != track_pos) begin
            mag          = (new_pos < track_pos) ? track_pos - new_pos : new_pos - track_pos;
            rep.mv_valid = 1'b1;
            rep.mv_rev   = new_pos < track_pos;
            rep.mv_count = (mag > SV_MAX_I) ? COUNT_MAX : mag[COUNT_W-1:0];
            track_pos    = new_pos;
        end
        rep.target   = new_pos[STEPF_W-1:0];
        rep.position = track_pos[STEPF_W-1:0];
        return rep;
    endfunction

    task automatic report_mismatch(string msg);
        err_count++;
        $display("%0t: mismatch: %s", $time, msg);
    endtask

    task automatic send_cmd(func_t fn, logic [SERVO_W-1:0] servo, int sv);
        int gap;
        s_axis_tuser  <= fn;
        s_axis_tdata  <= {{(S_TDATA_W - SV_W - SERVO_W){1'b0}}, sv[SV_W-1:0], servo};
        s_axis_tvalid <= 1'b1;
        do @(posedge aclk); while (!s_axis_tready);
        pending_moves.push_back(predict_move(fn, servo, sv));
        gap = no_idle ? 0 : $urandom_range(0, 19);
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
    endtask

    // Stops sending and waits until every pending move report has arrived.
    task automatic wait_drained();
        s_axis_tvalid <= 1'b0;
        while (pending_moves.size() != 0) @(posedge aclk);
        repeat (8) @(posedge aclk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge aclk);
        case (idx)
            REG_CAL:         cal_done = data[0];
            REG_SERVO_LOW:   servo_lo = data[SERVO_W-1:0];
            REG_SERVO_HIGH:  servo_hi = data[SERVO_W-1:0];
            REG_STEPS_LEFT:  steps_l  = longint'($signed(data[STEPF_W-1:0]));
            REG_STEPS_MID:   steps_m  = longint'($signed(data[STEPF_W-1:0]));
            REG_STEPS_RIGHT: steps_r  = longint'($signed(data[STEPF_W-1:0]));
            default: ;
        endcase
    endtask

    task automatic load_calibration(logic cal, int lo, int hi, int sl, int sm, int sr);
        write_reg(REG_SERVO_LOW, lo[CFG_DATA_W-1:0]);
        write_reg(REG_SERVO_HIGH, hi[CFG_DATA_W-1:0]);
        write_reg(REG_STEPS_LEFT, sl[CFG_DATA_W-1:0]);
        write_reg(REG_STEPS_MID, sm[CFG_DATA_W-1:0]);
        write_reg(REG_STEPS_RIGHT, sr[CFG_DATA_W-1:0]);
        write_reg(REG_CAL, {{(CFG_DATA_W-1){1'b0}}, cal});
        cfg_wr_en <= 1'b0;
        @(posedge aclk);
    endtask

    function automatic int rand_steps();
        case ($urandom_range(0, 5))
            0:       return STEP_MIN_I;
            1:       return STEP_MAX_I;
            2, 3:    return int'($urandom_range(0, 100000)) - 50000;
            default: return int'($urandom_range(0, 1048575)) + STEP_MIN_I;
        endcase
    endfunction

    function automatic int rand_servo_point();
        case ($urandom_range(0, 9))
            0:       return 0;
            1:       return SERVO_MAX_I;
            default: return $urandom_range(0, SERVO_MAX_I);
        endcase
    endfunction

    // Runs straight after reset, so every goto is ignored.
    task automatic test_uncalibrated();
        send_cmd(FN_GOTO, 16'hFFFF, 0);
        send_cmd(FN_HOME, 16'h0000, SV_MAX_I);
        send_cmd(FN_SET, 16'h0000, SV_MAX_I);
        send_cmd(FN_MOVE, 16'h0000, 0);
        send_cmd(FN_SET, 16'hFFFF, -SV_MAX_I);
        send_cmd(FN_MOVE, 16'h0000, -1);
        send_cmd(FN_MOVE, 16'h5A5A, SV_MAX_I);
        send_cmd(FN_MOVE, 16'hA5A5, -SV_MAX_I);
        send_cmd(FN_GOTO, 16'd1234, 77);
        wait_drained();
    endtask

    task automatic test_calibrated_map();
        load_calibration(1'b1, 1000, 3000, -5000, 100, 20000);
        // Unused register indexes must leave the calibration alone.
        write_reg(REG_SPARE_A, 20'hFFFFF);
        write_reg(REG_SPARE_B, 20'h12345);
        cfg_wr_en <= 1'b0;
        @(posedge aclk);
        send_cmd(FN_GOTO, 16'd0, 0);
        send_cmd(FN_GOTO, 16'd1000, 0);
        send_cmd(FN_GOTO, 16'd1499, 0);
        send_cmd(FN_GOTO, 16'd2000, 0);
        send_cmd(FN_GOTO, 16'd2001, 0);
        send_cmd(FN_GOTO, 16'd3000, 0);
        send_cmd(FN_GOTO, 16'hFFFF, 0);
        send_cmd(FN_HOME, 16'd2500, 0);
        wait_drained();
    endtask

    task automatic test_special_spans();
        // Both ends equal: each segment has a zero span.
        load_calibration(1'b1, 500, 500, -7, 13, 99);
        send_cmd(FN_GOTO, 16'd500, 0);
        send_cmd(FN_GOTO, 16'd501, 0);
        send_cmd(FN_GOTO, 16'd0, 0);
        wait_drained();
        // Left point above the right one.
        load_calibration(1'b1, 60000, 100, STEP_MAX_I, STEP_MIN_I, 300000);
        send_cmd(FN_GOTO, 16'd0, 0);
        send_cmd(FN_GOTO, 16'd30050, 0);
        send_cmd(FN_HOME, 16'hFFFF, 0);
        wait_drained();
        load_calibration(1'b1, 0, SERVO_MAX_I, STEP_MIN_I, STEP_MAX_I, STEP_MIN_I);
        send_cmd(FN_GOTO, 16'd32767, 0);
        send_cmd(FN_GOTO, 16'd32768, 0);
        send_cmd(FN_GOTO, 16'hFFFF, 0);
        wait_drained();
    endtask

    // The receiver holds off while the sender streams, so the block fills up.
    task automatic test_backpressure();
        int k;
        no_idle  = 1'b1;
        hold_req = 1'b1;
        for (k = 0; k < 12; k++) begin
            send_cmd(func_t'($urandom_range(0, 3)), 16'($urandom_range(0, SERVO_MAX_I)),
                     int'($urandom_range(0, 4000)) - 2000);
        end
        wait_drained();
        no_idle = 1'b0;
    endtask

    task automatic test_random();
        int    ph;
        int    k;
        int    lo;
        int    hi;
        int    pt;
        int    sv;
        func_t fn;
        for (ph = 0; ph < RAND_PHASES; ph++) begin
            lo = rand_servo_point();
            hi = ($urandom_range(0, 9) == 0) ? lo : rand_servo_point();
            load_calibration($urandom_range(0, 6) != 0, lo, hi,
                             rand_steps(), rand_steps(), rand_steps());
            no_idle = ($urandom_range(0, 3) == 0);
            for (k = 0; k < PHASE_ITEMS; k++) begin
                case ($urandom_range(0, 19))
                    0, 1, 2, 3, 4, 5, 6, 7, 8, 9: fn = FN_GOTO;
                    10, 11:                       fn = FN_HOME;
                    12, 13, 14, 15, 16:           fn = FN_MOVE;
                    default:                      fn = FN_SET;
                endcase
                // Targets near the calibration points exercise the segment edges.
                if ($urandom_range(0, 9) < 3) begin
                    case ($urandom_range(0, 3))
                        0:       pt = lo;
                        1:       pt = hi;
                        2:       pt = (lo + hi) / 2;
                        default: pt = (lo + hi) / 2 + 1;
                    endcase
                    pt = pt + int'($urandom_range(0, 4)) - 2;
                    if (pt < 0) pt = 0;
                    if (pt > SERVO_MAX_I) pt = SERVO_MAX_I;
                end else begin
                    pt = $urandom_range(0, SERVO_MAX_I);
                end
                if ($urandom_range(0, 1) == 0) sv = int'($urandom_range(0, 2 * SV_MAX_I)) - SV_MAX_I;
                else sv = int'($urandom_range(0, 4000)) - 2000;
                send_cmd(fn, pt[SERVO_W-1:0], sv);
            end
            wait_drained();
        end
        no_idle = 1'b0;
    endtask

    initial begin : rx_hold_timer
        forever begin
            wait (hold_req);
            rx_hold = 1'b1;
            repeat (HOLD_CYCLES) @(posedge aclk);
            rx_hold  = 1'b0;
            hold_req = 1'b0;
        end
    end

    initial begin : result_sink
        move_report_t got;
        move_report_t want;
        int           stall;
        m_axis_tready <= 1'b0;
        wait (aresetn === 1'b1);
        forever begin
            stall = no_idle ? 0 : $urandom_range(0, 19);
            if (stall > 0 || rx_hold) begin
                m_axis_tready <= 1'b0;
                repeat ((stall > 0) ? stall : 1) @(posedge aclk);
                while (rx_hold) @(posedge aclk);
            end
            m_axis_tready <= 1'b1;
            do @(posedge aclk); while (!m_axis_tvalid);
            got.mv_valid = m_axis_tdata[MV_VALID_BIT];
            got.mv_rev   = m_axis_tdata[MV_REV_BIT];
            got.mv_count = m_axis_tdata[MV_CNT_LSB +: COUNT_W];
            got.target   = m_axis_tdata[TGT_LSB +: STEPF_W];
            got.position = m_axis_tdata[POS_LSB +: STEPF_W];
            if (pending_moves.size() == 0) begin
                report_mismatch("result item with no command pending");
            end else begin
                want = pending_moves.pop_front();
                if (got.mv_valid !== want.mv_valid)
                    report_mismatch($sformatf("move_valid %0b, expected %0b",
                                              got.mv_valid, want.mv_valid));
                if (got.mv_rev !== want.mv_rev)
                    report_mismatch($sformatf("move_reverse %0b, expected %0b",
                                              got.mv_rev, want.mv_rev));
                if (got.mv_count !== want.mv_count)
                    report_mismatch($sformatf("move_count %0d, expected %0d",
                                              got.mv_count, want.mv_count));
                if (got.target !== want.target)
                    report_mismatch($sformatf("target_steps %0d, expected %0d",
                                              $signed(got.target), $signed(want.target)));
                if (got.position !== want.position)
                    report_mismatch($sformatf("position_now %0d, expected %0d",
                                              $signed(got.position), $signed(want.position)));
            end
        end
    end

    initial begin : run_limit
        #8_000_000;
        $display("servo_to_stepper_map verification failed");
        $finish;
    end

    initial begin : main_sequence
        aresetn       <= 1'b0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= '0;
        s_axis_tuser  <= FN_GOTO;
        cfg_wr_en     <= 1'b0;
        cfg_index     <= REG_CAL;
        cfg_data      <= '0;
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_uncalibrated();
        test_calibrated_map();
        test_special_spans();
        test_backpressure();
        test_random();
        wait_drained();
        repeat (TAIL_CYCLES) @(posedge aclk);
        if (err_count == 0 && pending_moves.size() == 0)
            $display("servo_to_stepper_map verification clean");
        else
            $display("servo_to_stepper_map verification failed");
        $finish;
    end

endmodule
